@@ src/csfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package csfr_pkg;

   localparam int FRAMES_DEFAULT = 16;
   localparam int FIU_W = 5;
   localparam int CAP_W = 3;
   localparam int KEY_W = 32;
   localparam int DATA_W = 32;
   localparam int PIN_W = 8;
   localparam int CNT_W = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [FIU_W-1:0] FRAMES_IN_USE_RESET = 5'd16;
   localparam logic [CAP_W-1:0] USAGE_CAP_RESET = 3'd5;
   localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;
   localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAMES_IN_USE = 1'b0,
      REG_USAGE_CAP     = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_GET   = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_UNPIN = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT           = 3'd0,
      ST_MISS          = 3'd1,
      ST_REPINNED      = 3'd2,
      ST_LOADED_FREE   = 3'd3,
      ST_LOADED_EVICT  = 3'd4,
      ST_UNPINNED      = 3'd5,
      ST_IGNORED       = 3'd6,
      ST_ALL_PINNED    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SWEEP_RD,
      S_SWEEP_CHK
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_SCAN_RD,
      DP_SCAN_NEXT,
      DP_FOUND,
      DP_MISS,
      DP_FILL,
      DP_SWEEP_INIT,
      DP_SWEEP_RD,
      DP_SWEEP_DEC,
      DP_VICTIM,
      DP_ALL_PINNED
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_busy;
      logic is_put;
      logic scan_end;
      logic match;
      logic room;
      logic sweep_end;
      logic pinned;
      logic used;
   } dp_status_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
      logic [CAP_W-1:0]  usage;
      logic [PIN_W-1:0]  pins;
   } frame_type;

endpackage
`default_nettype wire

@@ src/csfr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csfr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire csfr_pkg::dp_status_type dp_status,
   output csfr_pkg::dp_cmd_type         dp_cmd
);

   csfr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csfr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csfr_pkg::S_IDLE: begin
            if (req_valid && !dp_status.rsp_busy) state_in = csfr_pkg::S_SCAN_RD;
         end
         csfr_pkg::S_SCAN_RD: begin
            if (!dp_status.scan_end) begin
               state_in = csfr_pkg::S_SCAN_CHK;
            end else if (dp_status.is_put && !dp_status.room) begin
               state_in = csfr_pkg::S_SWEEP_RD;
            end else begin
               state_in = csfr_pkg::S_IDLE;
            end
         end
         csfr_pkg::S_SCAN_CHK: begin
            state_in = dp_status.match ? csfr_pkg::S_IDLE : csfr_pkg::S_SCAN_RD;
         end
         csfr_pkg::S_SWEEP_RD: begin
            state_in = dp_status.sweep_end ? csfr_pkg::S_IDLE : csfr_pkg::S_SWEEP_CHK;
         end
         csfr_pkg::S_SWEEP_CHK: begin
            if (dp_status.pinned || dp_status.used) begin
               state_in = csfr_pkg::S_SWEEP_RD;
            end else begin
               state_in = csfr_pkg::S_IDLE;
            end
         end
         default: state_in = csfr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dp_cmd = csfr_pkg::DP_NOP;
      case (state_ff)
         csfr_pkg::S_IDLE: begin
            req_ready = !dp_status.rsp_busy;
            if (req_valid && !dp_status.rsp_busy) dp_cmd = csfr_pkg::DP_LOAD;
         end
         csfr_pkg::S_SCAN_RD: begin
            if (!dp_status.scan_end) begin
               dp_cmd = csfr_pkg::DP_SCAN_RD;
            end else if (dp_status.is_put && dp_status.room) begin
               dp_cmd = csfr_pkg::DP_FILL;
            end else if (dp_status.is_put) begin
               dp_cmd = csfr_pkg::DP_SWEEP_INIT;
            end else begin
               dp_cmd = csfr_pkg::DP_MISS;
            end
         end
         csfr_pkg::S_SCAN_CHK: begin
            dp_cmd = dp_status.match ? csfr_pkg::DP_FOUND : csfr_pkg::DP_SCAN_NEXT;
         end
         csfr_pkg::S_SWEEP_RD: begin
            dp_cmd = dp_status.sweep_end ? csfr_pkg::DP_ALL_PINNED : csfr_pkg::DP_SWEEP_RD;
         end
         csfr_pkg::S_SWEEP_CHK: begin
            if (dp_status.pinned) begin
               dp_cmd = csfr_pkg::DP_NOP;
            end else if (dp_status.used) begin
               dp_cmd = csfr_pkg::DP_SWEEP_DEC;
            end else begin
               dp_cmd = csfr_pkg::DP_VICTIM;
            end
         end
         default: dp_cmd = csfr_pkg::DP_NOP;
      endcase
   end

endmodule
`default_nettype wire

@@ src/csfr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csfr_datapath #(
   parameter int FRAMES = csfr_pkg::FRAMES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire csfr_pkg::dp_cmd_type              dp_cmd,
   output csfr_pkg::dp_status_type                dp_status,
   input  wire logic                              csr_write_enable,
   input  wire logic [csfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [csfr_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  wire logic [1:0]                        req_command,
   input  wire logic [csfr_pkg::KEY_W-1:0]        req_lookup_key,
   input  wire logic [csfr_pkg::DATA_W-1:0]       req_data_word,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_status,
   output logic [csfr_pkg::DATA_W-1:0]            rsp_data_out,
   output logic [$clog2(FRAMES)-1:0]              rsp_slot,
   output logic [csfr_pkg::KEY_W-1:0]             rsp_evicted_key,
   output logic [csfr_pkg::CAP_W-1:0]             rsp_usage_after,
   output logic [csfr_pkg::PIN_W-1:0]             rsp_pin_after,
   output logic [csfr_pkg::CNT_W-1:0]             rsp_hit_count,
   output logic [csfr_pkg::CNT_W-1:0]             rsp_miss_count
);

   localparam int SLOT_W = $clog2(FRAMES);
   localparam int FILL_W = $clog2(FRAMES + 1);
   localparam int BND_W = $clog2(8 * FRAMES + 2);

   csfr_pkg::frame_type mem [FRAMES];
   csfr_pkg::frame_type rd_ff;
   csfr_pkg::frame_type wdata;
   logic                we;
   logic [SLOT_W-1:0]   waddr;
   logic                re;
   logic [SLOT_W-1:0]   raddr;

   logic [csfr_pkg::FIU_W-1:0]  fiu_ff, fiu_in;
   logic [csfr_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic [csfr_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [csfr_pkg::DATA_W-1:0] dat_ff, dat_in;
   logic [FILL_W-1:0]           idx_ff, idx_in;
   logic [FILL_W-1:0]           filled_ff, filled_in;
   logic [SLOT_W-1:0]           hand_ff, hand_in;
   logic [SLOT_W-1:0]           cur_ff, cur_in;
   logic [BND_W-1:0]            step_ff, step_in;
   logic [BND_W-1:0]            bound_ff, bound_in;
   logic [csfr_pkg::CNT_W-1:0]  hits_ff, hits_in;
   logic [csfr_pkg::CNT_W-1:0]  misses_ff, misses_in;

   logic                        rv_ff, rv_in;
   logic [2:0]                  st_ff, st_in;
   logic [csfr_pkg::DATA_W-1:0] dout_ff, dout_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [csfr_pkg::KEY_W-1:0]  ekey_ff, ekey_in;
   logic [csfr_pkg::CAP_W-1:0]  use_ff, use_in;
   logic [csfr_pkg::PIN_W-1:0]  pin_ff, pin_in;

   logic [csfr_pkg::CAP_W-1:0]  cap_eff;
   logic [31:0]                 frames_eff;
   logic [csfr_pkg::CAP_W-1:0]  use_up;
   logic [csfr_pkg::PIN_W-1:0]  pin_up;
   logic [SLOT_W-1:0]           hand_start;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   always_comb begin
      cap_eff = (cap_ff == '0) ? csfr_pkg::CAP_W'(1) : cap_ff;
      if (fiu_ff == '0) begin
         frames_eff = 32'd1;
      end else if (32'(fiu_ff) > 32'(FRAMES)) begin
         frames_eff = 32'(FRAMES);
      end else begin
         frames_eff = 32'(fiu_ff);
      end
      use_up = (rd_ff.usage < cap_eff) ? rd_ff.usage + 1'b1 : rd_ff.usage;
      pin_up = (rd_ff.pins != csfr_pkg::PIN_MAX) ? rd_ff.pins + 1'b1 : rd_ff.pins;
      hand_start = (32'(hand_ff) >= 32'(filled_ff)) ? '0 : hand_ff;
   end

   always_comb begin
      dp_status.rsp_busy  = rv_ff;
      dp_status.is_put    = (cmd_ff == csfr_pkg::CMD_PUT);
      dp_status.scan_end  = (idx_ff >= filled_ff);
      dp_status.match     = (rd_ff.key == key_ff);
      dp_status.room      = (32'(filled_ff) < frames_eff);
      dp_status.sweep_end = (step_ff >= bound_ff) || (filled_ff == '0);
      dp_status.pinned    = (rd_ff.pins != '0);
      dp_status.used      = (rd_ff.usage != '0);
   end

   always_comb begin
      fiu_in = fiu_ff;
      cap_in = cap_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      dat_in = dat_ff;
      idx_in = idx_ff;
      filled_in = filled_ff;
      hand_in = hand_ff;
      cur_in = cur_ff;
      step_in = step_ff;
      bound_in = bound_ff;
      hits_in = hits_ff;
      misses_in = misses_ff;
      rv_in = rv_ff && !rsp_ready;
      st_in = st_ff;
      dout_in = dout_ff;
      slot_in = slot_ff;
      ekey_in = ekey_ff;
      use_in = use_ff;
      pin_in = pin_ff;
      we = 1'b0;
      waddr = cur_ff;
      wdata = rd_ff;
      re = 1'b0;
      raddr = idx_ff[SLOT_W-1:0];

      if (csr_write_enable) begin
         case (csr_index)
            csfr_pkg::REG_FRAMES_IN_USE: fiu_in = csr_write_data[csfr_pkg::FIU_W-1:0];
            csfr_pkg::REG_USAGE_CAP:     cap_in = csr_write_data[csfr_pkg::CAP_W-1:0];
            default: ;
         endcase
      end

      case (dp_cmd)
         csfr_pkg::DP_LOAD: begin
            cmd_in = req_command;
            key_in = req_lookup_key;
            dat_in = req_data_word;
            idx_in = '0;
         end
         csfr_pkg::DP_SCAN_RD: begin
            re = 1'b1;
         end
         csfr_pkg::DP_SCAN_NEXT: begin
            idx_in = idx_ff + 1'b1;
         end
         csfr_pkg::DP_FOUND: begin
            rv_in = 1'b1;
            dout_in = '0;
            ekey_in = '0;
            slot_in = idx_ff[SLOT_W-1:0];
            waddr = idx_ff[SLOT_W-1:0];
            use_in = rd_ff.usage;
            pin_in = rd_ff.pins;
            st_in = csfr_pkg::ST_IGNORED;
            case (cmd_ff)
               csfr_pkg::CMD_GET: begin
                  we = 1'b1;
                  wdata.usage = use_up;
                  wdata.pins = pin_up;
                  use_in = use_up;
                  pin_in = pin_up;
                  dout_in = rd_ff.data;
                  st_in = csfr_pkg::ST_HIT;
                  if (hits_ff != csfr_pkg::COUNT_MAX) hits_in = hits_ff + 1'b1;
               end
               csfr_pkg::CMD_PUT: begin
                  we = 1'b1;
                  wdata.usage = use_up;
                  wdata.pins = pin_up;
                  wdata.data = dat_ff;
                  use_in = use_up;
                  pin_in = pin_up;
                  st_in = csfr_pkg::ST_REPINNED;
               end
               csfr_pkg::CMD_UNPIN: begin
                  if (rd_ff.pins != '0) begin
                     we = 1'b1;
                     wdata.pins = rd_ff.pins - 1'b1;
                     pin_in = rd_ff.pins - 1'b1;
                     st_in = csfr_pkg::ST_UNPINNED;
                  end
               end
               default: begin
                  slot_in = '0;
                  use_in = '0;
                  pin_in = '0;
               end
            endcase
         end
         csfr_pkg::DP_MISS: begin
            rv_in = 1'b1;
            dout_in = '0;
            ekey_in = '0;
            slot_in = '0;
            use_in = '0;
            pin_in = '0;
            if (cmd_ff == csfr_pkg::CMD_GET) begin
               st_in = csfr_pkg::ST_MISS;
               if (misses_ff != csfr_pkg::COUNT_MAX) misses_in = misses_ff + 1'b1;
            end else begin
               st_in = csfr_pkg::ST_IGNORED;
            end
         end
         csfr_pkg::DP_FILL: begin
            we = 1'b1;
            waddr = filled_ff[SLOT_W-1:0];
            wdata.key = key_ff;
            wdata.data = dat_ff;
            wdata.usage = csfr_pkg::CAP_W'(1);
            wdata.pins = csfr_pkg::PIN_W'(1);
            filled_in = filled_ff + 1'b1;
            rv_in = 1'b1;
            st_in = csfr_pkg::ST_LOADED_FREE;
            dout_in = '0;
            ekey_in = '0;
            slot_in = filled_ff[SLOT_W-1:0];
            use_in = csfr_pkg::CAP_W'(1);
            pin_in = csfr_pkg::PIN_W'(1);
         end
         csfr_pkg::DP_SWEEP_INIT: begin
            step_in = '0;
            bound_in = BND_W'((32'(cap_eff) + 32'd1) * 32'(filled_ff) + 32'd1);
            hand_in = hand_start;
         end
         csfr_pkg::DP_SWEEP_RD: begin
            re = 1'b1;
            raddr = hand_ff;
            cur_in = hand_ff;
            hand_in = (32'(hand_ff) + 32'd1 == 32'(filled_ff)) ? '0 : hand_ff + 1'b1;
            step_in = step_ff + 1'b1;
         end
         csfr_pkg::DP_SWEEP_DEC: begin
            we = 1'b1;
            wdata.usage = rd_ff.usage - 1'b1;
         end
         csfr_pkg::DP_VICTIM: begin
            we = 1'b1;
            wdata.key = key_ff;
            wdata.data = dat_ff;
            wdata.usage = csfr_pkg::CAP_W'(1);
            wdata.pins = csfr_pkg::PIN_W'(1);
            rv_in = 1'b1;
            st_in = csfr_pkg::ST_LOADED_EVICT;
            dout_in = '0;
            ekey_in = rd_ff.key;
            slot_in = cur_ff;
            use_in = csfr_pkg::CAP_W'(1);
            pin_in = csfr_pkg::PIN_W'(1);
         end
         csfr_pkg::DP_ALL_PINNED: begin
            rv_in = 1'b1;
            st_in = csfr_pkg::ST_ALL_PINNED;
            dout_in = '0;
            ekey_in = '0;
            slot_in = '0;
            use_in = '0;
            pin_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= csfr_pkg::FRAMES_IN_USE_RESET;
         cap_ff <= csfr_pkg::USAGE_CAP_RESET;
         filled_ff <= '0;
         hand_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
         rv_ff <= 1'b0;
         idx_ff <= '0;
         step_ff <= '0;
         bound_ff <= '0;
      end else begin
         fiu_ff <= fiu_in;
         cap_ff <= cap_in;
         filled_ff <= filled_in;
         hand_ff <= hand_in;
         hits_ff <= hits_in;
         misses_ff <= misses_in;
         rv_ff <= rv_in;
         idx_ff <= idx_in;
         step_ff <= step_in;
         bound_ff <= bound_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      dat_ff <= dat_in;
      cur_ff <= cur_in;
      st_ff <= st_in;
      dout_ff <= dout_in;
      slot_ff <= slot_in;
      ekey_ff <= ekey_in;
      use_ff <= use_in;
      pin_ff <= pin_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_data_out = dout_ff;
   assign rsp_slot = slot_ff;
   assign rsp_evicted_key = ekey_ff;
   assign rsp_usage_after = use_ff;
   assign rsp_pin_after = pin_ff;
   assign rsp_hit_count = hits_ff;
   assign rsp_miss_count = misses_ff;

endmodule
`default_nettype wire

@@ src/clock_sweep_frame_replacer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Frame pool with clock-sweep replacement, one item at a time. The frames sit in a single-port
// memory, so each frame visited is first read and then examined. A command scans the filled
// frames in order from slot zero until it finds its key; a miss, a free fill or a command on
// an uncached key scans them all. A put that has to evict then sweeps from the clock hand,
// reading and examining each frame, and reports all-pinned when the sweep runs out. The sweep
// visits at most (usage_cap + 1) * filled frames + 1 frames, a usage cap of zero counting as
// one. A new item can be taken in the cycle after the previous result has been accepted.
// There is no clearing pass after reset.
module clock_sweep_frame_replacer #(
   parameter int FRAMES = csfr_pkg::FRAMES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [csfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [csfr_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_command,
   input  wire logic [csfr_pkg::KEY_W-1:0]        req_lookup_key,
   input  wire logic [csfr_pkg::DATA_W-1:0]       req_data_word,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_status,
   output logic [csfr_pkg::DATA_W-1:0]            rsp_data_out,
   output logic [$clog2(FRAMES)-1:0]              rsp_slot,
   output logic [csfr_pkg::KEY_W-1:0]             rsp_evicted_key,
   output logic [csfr_pkg::CAP_W-1:0]             rsp_usage_after,
   output logic [csfr_pkg::PIN_W-1:0]             rsp_pin_after,
   output logic [csfr_pkg::CNT_W-1:0]             rsp_hit_count,
   output logic [csfr_pkg::CNT_W-1:0]             rsp_miss_count
);

   csfr_pkg::dp_cmd_type    dp_cmd;
   csfr_pkg::dp_status_type dp_status;

   csfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   csfr_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_lookup_key   (req_lookup_key),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_slot         (rsp_slot),
      .rsp_evicted_key  (rsp_evicted_key),
      .rsp_usage_after  (rsp_usage_after),
      .rsp_pin_after    (rsp_pin_after),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count)
   );

   a_accept_when_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !rsp_valid)
      else $error("item accepted while a result is pending");

   a_all_pinned_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == csfr_pkg::ST_ALL_PINNED) |->
         (rsp_slot == '0 && rsp_pin_after == '0 && rsp_usage_after == '0))
      else $error("all-pinned result carries frame fields");

   a_loaded_fresh: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == csfr_pkg::ST_LOADED_FREE ||
                     rsp_status == csfr_pkg::ST_LOADED_EVICT)) |->
         (rsp_pin_after == 8'd1 && rsp_usage_after == 3'd1))
      else $error("loaded frame does not start with one pin and usage one");

endmodule
`default_nettype wire
